### hdl/cddr_pkg.sv
// ----------------------------------------------------------------------------
// cddr_pkg: shared types and constants for the character display refresher
// Default geometry, field widths, register reset values, transfer kinds,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package cddr_pkg;

  // default display geometry
  localparam int ROWS_DEF    = 4;
  localparam int COLUMNS_DEF = 20;

  // fixed field widths
  localparam int DATA_W = 8;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 5;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 2;

  // configuration registers: one cursor base per row
  localparam int NUM_BASES = 4;
  localparam logic [DATA_W-1:0] ROW0_BASE_RST = 8'h80;
  localparam logic [DATA_W-1:0] ROW1_BASE_RST = 8'hC0;
  localparam logic [DATA_W-1:0] ROW2_BASE_RST = 8'h94;
  localparam logic [DATA_W-1:0] ROW3_BASE_RST = 8'hD4;

  // input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR = 2'd0,
    KIND_SKIP = 2'd1,
    KIND_WRAP = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic write_text;
    logic advance;
    logic wrap;
    logic emit_char;
    logic emit_skip;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end;
    logic differ;
    logic skip;
    logic slot_free;
  } sts_t;

endpackage

### hdl/cddr_ram.sv
// ----------------------------------------------------------------------------
// cddr_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered (read-first).
// ----------------------------------------------------------------------------
module cddr_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 80,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/cddr_ctrl.sv
// ----------------------------------------------------------------------------
// cddr_ctrl: refresh controller
// Accepts transactions, sequences the cell scan and issues datapath commands.
// ----------------------------------------------------------------------------
module cddr_ctrl
  import cddr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_command,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_STEP) begin
            state_nxt = ST_PRIME;
          end else begin
            cmd.write_text = 1'b1;
          end
        end
      end
      // wait state so that the current cell is read fresh
      ST_PRIME: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.at_end) begin
          if (sts.slot_free) begin
            cmd.wrap  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else if (sts.differ) begin
          if (sts.slot_free) begin
            if (sts.skip) begin
              cmd.emit_skip = 1'b1;
            end else begin
              cmd.emit_char = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.advance = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/cddr_dp.sv
// ----------------------------------------------------------------------------
// cddr_dp: refresh datapath
// Text and shadow stores with valid bits, scan position, cursor bases and the
// result register.
// ----------------------------------------------------------------------------
module cddr_dp
  import cddr_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_column,
  input  logic [DATA_W-1:0] in_char_code,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_character,
  output logic [DATA_W-1:0] out_byte,
  output logic [KIND_W-1:0] out_transfer_kind
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS + 1);

  logic [RW-1:0]     row_r, row_nxt, row_inc;
  logic [CW-1:0]     col_r, col_nxt;
  logic              skip_r, skip_nxt;
  logic [DATA_W-1:0] base_r [NUM_BASES];

  logic [CELLS-1:0]  text_vld_r, shadow_vld_r;
  logic              text_vq_r, shadow_vq_r;
  logic [DATA_W-1:0] text_q, shadow_q, text_eff, shadow_eff;

  logic              wr_ok;
  logic [AW-1:0]     wr_addr, cur_addr, rd_addr;

  logic              out_valid_r;
  logic              out_is_char_r;
  logic [DATA_W-1:0] out_byte_r;
  kind_t             out_kind_r;

  // --- addresses ---
  assign wr_ok    = ({1'b0, in_row} < (ROW_W + 1)'(ROWS))
                 && ({1'b0, in_column} < (COL_W + 1)'(COLUMNS));
  assign wr_addr  = AW'(AW'(in_row) * AW'(COLUMNS) + AW'(in_column));
  assign cur_addr = AW'(AW'(row_r) * AW'(COLUMNS) + AW'(col_r));
  // read the cell the scan will sit on next cycle; park past the row end
  assign rd_addr  = (col_nxt < CW'(COLUMNS))
                  ? AW'(AW'(row_nxt) * AW'(COLUMNS) + AW'(col_nxt)) : '0;

  assign row_inc = (row_r == RW'(ROWS - 1)) ? '0 : RW'(row_r + 1'b1);

  // --- stores ---
  cddr_ram #(.WIDTH(DATA_W), .DEPTH(CELLS), .ADDR_W(AW)) u_text_ram (
    .clk   (clk),
    .we    (cmd.write_text && wr_ok),
    .waddr (wr_addr),
    .wdata (in_char_code),
    .raddr (rd_addr),
    .rdata (text_q)
  );

  cddr_ram #(.WIDTH(DATA_W), .DEPTH(CELLS), .ADDR_W(AW)) u_shadow_ram (
    .clk   (clk),
    .we    (cmd.emit_char),
    .waddr (cur_addr),
    .wdata (text_eff),
    .raddr (rd_addr),
    .rdata (shadow_q)
  );

  // unwritten cells read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_vld_r   <= '0;
      shadow_vld_r <= '0;
    end else begin
      if (cmd.write_text && wr_ok) begin
        text_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.emit_char) begin
        shadow_vld_r[cur_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    text_vq_r   <= text_vld_r[rd_addr];
    shadow_vq_r <= shadow_vld_r[rd_addr];
  end

  assign text_eff   = text_vq_r ? text_q : '0;
  assign shadow_eff = shadow_vq_r ? shadow_q : '0;

  // --- scan position ---
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    skip_nxt = skip_r;
    if (cmd.advance) begin
      col_nxt  = CW'(col_r + 1'b1);
      skip_nxt = 1'b1;
    end
    if (cmd.emit_char) begin
      col_nxt = CW'(col_r + 1'b1);
    end
    if (cmd.emit_skip) begin
      skip_nxt = 1'b0;
    end
    if (cmd.wrap) begin
      row_nxt = row_inc;
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      skip_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      skip_r <= skip_nxt;
    end
  end

  // --- cursor bases ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r[0] <= ROW0_BASE_RST;
      base_r[1] <= ROW1_BASE_RST;
      base_r[2] <= ROW2_BASE_RST;
      base_r[3] <= ROW3_BASE_RST;
    end else if (cfg_wr_en) begin
      base_r[cfg_index] <= cfg_wdata;
    end
  end

  // --- result register ---
  assign sts.at_end    = (col_r == CW'(COLUMNS));
  assign sts.differ    = (text_eff != shadow_eff);
  assign sts.skip      = skip_r;
  assign sts.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_char || cmd.emit_skip || cmd.wrap) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_char) begin
      out_is_char_r <= 1'b1;
      out_byte_r    <= text_eff;
      out_kind_r    <= KIND_CHAR;
    end else if (cmd.emit_skip) begin
      out_is_char_r <= 1'b0;
      out_byte_r    <= DATA_W'(base_r[ROW_W'(row_r)] + DATA_W'(col_r));
      out_kind_r    <= KIND_SKIP;
    end else if (cmd.wrap) begin
      out_is_char_r <= 1'b0;
      out_byte_r    <= base_r[ROW_W'(row_inc)];
      out_kind_r    <= KIND_WRAP;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_is_character  = out_is_char_r;
  assign out_byte          = out_byte_r;
  assign out_transfer_kind = out_kind_r;

endmodule

### hdl/char_display_diff_refresh.sv
// ----------------------------------------------------------------------------
// char_display_diff_refresh: differential refresh engine for a character LCD
// Keeps a text buffer and a shadow of the display contents; each step
// transaction yields one transfer: a character, or a cursor move.
// ----------------------------------------------------------------------------
//
//   channel  ports                                         direction
//   -------  --------------------------------------------  ---------
//   in       in_valid/in_ready, command, row, column, code  sink
//   out      out_valid/out_ready, is_character, byte, kind  source
//   cfg      cfg_wr_en, cfg_index, cfg_wdata                write only
//
// A write transaction updates the text buffer in the accept cycle and the
// engine is ready again the next cycle. A step transaction first primes the
// read of the current cell, then scans cells in turn until one differs or
// the row end is reached (at most COLUMNS + 1 cells visited). Reset is
// synchronous; the buffers read as zero after reset through per-cell valid
// bits. A result waiting in the output register does not block input; the
// scan holds on its final cell until that slot frees.
// ----------------------------------------------------------------------------
module char_display_diff_refresh
  import cddr_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input transactions
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_command,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_column,
  input  logic [DATA_W-1:0] in_char_code,
  // result transactions
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_character,
  output logic [DATA_W-1:0] out_byte,
  output logic [KIND_W-1:0] out_transfer_kind,
  // configuration writes
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequence: accept, prime the buffer read, scan cells
  cddr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd)
  );

  // buffers, scan position, cursor bases and output register
  cddr_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_row            (in_row),
    .in_column         (in_column),
    .in_char_code      (in_char_code),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_character  (out_is_character),
    .out_byte          (out_byte),
    .out_transfer_kind (out_transfer_kind)
  );

endmodule
